// File: src/tvcp_pkg.sv
// Shared types, constants and helpers for the tag/value checksum parser.
package tvcp_pkg;

	localparam logic [7:0]  EQ_BYTE      = 8'd61;
	localparam logic [7:0]  CHAR_0       = 8'd48;
	localparam logic [7:0]  CHAR_1       = 8'd49;
	localparam logic [7:0]  CHAR_9       = 8'd57;
	localparam logic [7:0]  TEN_TAG_SUM  = 8'd97;
	localparam logic [7:0]  DELIM_RESET  = 8'd124;
	localparam logic [15:0] SAT16        = 16'hFFFF;
	localparam logic [11:0] SAT12        = 12'hFFF;
	localparam logic [1:0]  TAG_LEN_MAX  = 2'd3;
	localparam logic [1:0]  TAG_LEN_TEN  = 2'd2;

	localparam int          PADDR_W      = 3;
	localparam logic        REG_DELIM    = 1'b0;

	typedef struct packed {
		logic [15:0] tag_number;
		logic        tag_is_numeric;
		logic [15:0] value_number;
		logic        value_has_digit;
		logic [11:0] value_length;
		logic        is_checksum_field;
		logic        checksum_ok;
		logic [7:0]  running_sum;
	} result_t;

	// acc*10 + digit, saturating at 16 bits
	function automatic logic [15:0] dec_push(input logic [15:0] acc, input logic [3:0] digit);
		logic [19:0] n;
		n = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, digit};
		return (n > {4'd0, SAT16}) ? SAT16 : n[15:0];
	endfunction

endpackage

// File: src/tvcp_apb.sv
// APB register block: holds the field delimiter byte.
module tvcp_apb import tvcp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [7:0]         delim
);

	logic [7:0] delim_q;
	logic       reg_idx;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign delim   = delim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_DELIM) begin
			delim_q <= pwdata[7:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DELIM: prdata = {24'd0, delim_q};
			default:   prdata = 32'd0;
		endcase
	end

endmodule

// File: src/tvcp_field.sv
// Per-field parse state, running checksum and result formation for one byte.
module tvcp_field import tvcp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	input  logic [7:0] delim,
	output logic       emit,
	output result_t    result
);

	logic        in_tag_q;
	logic [15:0] tag_accum_q;
	logic [1:0]  tag_len_q;
	logic        tag_nondigit_q;
	logic        tag_ten_q;
	logic [15:0] value_accum_q;
	logic        value_open_q;
	logic        value_digit_q;
	logic [11:0] value_len_q;
	logic [7:0]  byte_sum_q;

	logic       is_delim;
	logic       is_eq;
	logic       is_digit;
	logic [3:0] digit;
	logic       is_ten;
	logic [7:0] sum_before;

	assign is_delim   = (byte_s1 == delim);
	assign is_eq      = (byte_s1 == EQ_BYTE);
	assign is_digit   = (byte_s1 >= CHAR_0) && (byte_s1 <= CHAR_9);
	assign digit      = byte_s1[3:0];
	assign is_ten     = tag_ten_q && (tag_len_q == TAG_LEN_TEN);
	assign sum_before = byte_sum_q - TEN_TAG_SUM;
	assign emit       = step && is_delim;

	always_comb begin
		result.tag_number        = tag_accum_q;
		result.tag_is_numeric    = (tag_len_q != 2'd0) && !tag_nondigit_q;
		result.value_number      = value_accum_q;
		result.value_has_digit   = value_digit_q;
		result.value_length      = value_len_q;
		result.is_checksum_field = is_ten;
		result.checksum_ok       = is_ten && value_digit_q && (value_accum_q == {8'd0, sum_before});
		result.running_sum       = is_ten ? sum_before : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q       <= 1'b1;
			tag_accum_q    <= 16'd0;
			tag_len_q      <= 2'd0;
			tag_nondigit_q <= 1'b0;
			tag_ten_q      <= 1'b1;
			value_accum_q  <= 16'd0;
			value_open_q   <= 1'b1;
			value_digit_q  <= 1'b0;
			value_len_q    <= 12'd0;
			byte_sum_q     <= 8'd0;
		end else if (step) begin
			if (is_delim) begin
				// close field; checksum field restarts the message sum
				byte_sum_q     <= is_ten ? 8'd0 : byte_sum_q + EQ_BYTE + 8'd1;
				in_tag_q       <= 1'b1;
				tag_accum_q    <= 16'd0;
				tag_len_q      <= 2'd0;
				tag_nondigit_q <= 1'b0;
				tag_ten_q      <= 1'b1;
				value_accum_q  <= 16'd0;
				value_open_q   <= 1'b1;
				value_digit_q  <= 1'b0;
				value_len_q    <= 12'd0;
			end else if (is_eq) begin
				in_tag_q <= 1'b0;
			end else if (in_tag_q) begin
				byte_sum_q <= byte_sum_q + byte_s1;
				case (tag_len_q)
					2'd0:    if (byte_s1 != CHAR_1) tag_ten_q <= 1'b0;
					2'd1:    if (byte_s1 != CHAR_0) tag_ten_q <= 1'b0;
					default: tag_ten_q <= 1'b0;
				endcase
				if (tag_len_q != TAG_LEN_MAX) tag_len_q <= tag_len_q + 2'd1;
				if (!is_digit) begin
					tag_nondigit_q <= 1'b1;
				end else if (!tag_nondigit_q) begin
					tag_accum_q <= dec_push(tag_accum_q, digit);
				end
			end else begin
				// checksum value bytes stay out of the sum
				if (!is_ten) byte_sum_q <= byte_sum_q + byte_s1;
				if (value_len_q != SAT12) value_len_q <= value_len_q + 12'd1;
				if (value_open_q) begin
					if (is_digit) begin
						value_accum_q <= dec_push(value_accum_q, digit);
						value_digit_q <= 1'b1;
					end else begin
						value_open_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// File: src/tag_value_checksum_parser.sv
// Top level of the streaming tag=value parser with modulo-256 checksum check.
//
// One message byte per word enters on the byte channel; every delimiter byte yields one
// result word describing the field it closes (tag number, value number and length, and for
// tag "10" the checksum compare against the byte sum of the message so far). Other bytes
// yield no result. The block takes one byte every cycle: a byte is held in an input
// register, where the field state and the running sum are updated by short logic (one
// multiply-by-ten add, one 8-bit add, a few compares), and a delimiter loads the result
// register, which drives result valid. The result register holds a word until taken;
// while it is full and not being taken, the byte in the input register waits (delimiter or
// not) and the byte channel stalls, so throughput stays one byte per cycle as long as
// results are taken when offered. The delimiter (reset '|', 124) lives in an APB register
// at byte address 0 and is meant to be changed only while the block is idle.
module tag_value_checksum_parser import tvcp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// byte channel
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         in_byte,
	// result channel
	output logic               result_valid,
	input  logic               result_ready,
	output logic [15:0]        tag_number,
	output logic               tag_is_numeric,
	output logic [15:0]        value_number,
	output logic               value_has_digit,
	output logic [11:0]        value_length,
	output logic               is_checksum_field,
	output logic               checksum_ok,
	output logic [7:0]         running_sum,
	// APB
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       slot_free;
	logic       step;
	logic       emit;
	logic [7:0] delim;
	result_t    result;
	result_t    result_q;
	logic       out_valid_q;

	tvcp_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.delim   (delim)
	);

	// result slot can take a new word this cycle
	assign slot_free  = !out_valid_q || result_ready;
	// byte in stage 1 is consumed once its possible result has somewhere to go
	assign step       = valid_s1 && slot_free;
	assign byte_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) byte_s1 <= in_byte;
	end

	tvcp_field u_field (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.delim   (delim),
		.emit    (emit),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) result_q <= result;
	end

	assign result_valid      = out_valid_q;
	assign tag_number        = result_q.tag_number;
	assign tag_is_numeric    = result_q.tag_is_numeric;
	assign value_number      = result_q.value_number;
	assign value_has_digit   = result_q.value_has_digit;
	assign value_length      = result_q.value_length;
	assign is_checksum_field = result_q.is_checksum_field;
	assign checksum_ok       = result_q.checksum_ok;
	assign running_sum       = result_q.running_sum;

endmodule

// File: src/tvcp_checker.sv
// Port-level checks for the tag/value checksum parser, bound to the top level.
module tvcp_checker import tvcp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] value_number,
	input logic        value_has_digit,
	input logic        is_checksum_field,
	input logic        checksum_ok,
	input logic [7:0]  running_sum
);

	// a stalled result word stays valid and keeps its running sum and checksum flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(running_sum)
			&& $stable(checksum_ok))
		else $error("result word changed while stalled");

	a_ok_needs_ten: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && checksum_ok |-> is_checksum_field)
		else $error("checksum_ok on a non-checksum field");

	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && checksum_ok |-> value_has_digit
			&& value_number == {8'd0, running_sum})
		else $error("checksum_ok without matching value");

	a_sum_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_checksum_field |-> running_sum == 8'd0)
		else $error("running_sum nonzero on ordinary field");

endmodule

bind tag_value_checksum_parser tvcp_checker u_tvcp_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.result_valid      (result_valid),
	.result_ready      (result_ready),
	.value_number      (value_number),
	.value_has_digit   (value_has_digit),
	.is_checksum_field (is_checksum_field),
	.checksum_ok       (checksum_ok),
	.running_sum       (running_sum)
);
